// File: rtl/accalu_pkg.sv
package accalu_pkg;

  localparam int unsigned DATA_W  = 8;
  localparam int unsigned WIDE_W  = 16;
  localparam int unsigned FLAGS_W = 6;
  localparam int unsigned CMD_W   = 5;

  // flag positions: H I N Z V C
  localparam int unsigned FL_C = 0;
  localparam int unsigned FL_V = 1;
  localparam int unsigned FL_Z = 2;
  localparam int unsigned FL_N = 3;
  localparam int unsigned FL_I = 4;
  localparam int unsigned FL_H = 5;

  localparam logic [FLAGS_W-1:0] FLAGS_RESET = 6'h10;
  localparam logic [1:0]         CCR_TOP     = 2'b11;

  localparam logic [DATA_W-1:0] BYTE_MSB    = 8'h80;
  localparam logic [DATA_W-1:0] BYTE_MAXPOS = 8'h7F;
  localparam logic [DATA_W-1:0] ADJ_LO      = 8'h06;
  localparam logic [DATA_W-1:0] ADJ_HI      = 8'h60;
  localparam logic [3:0]        BCD_MAX     = 4'd9;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD  = 5'd0,
    CMD_ADC  = 5'd1,
    CMD_SUB  = 5'd2,
    CMD_SBC  = 5'd3,
    CMD_AND  = 5'd4,
    CMD_OR   = 5'd5,
    CMD_EOR  = 5'd6,
    CMD_NEG  = 5'd7,
    CMD_COM  = 5'd8,
    CMD_INC  = 5'd9,
    CMD_DEC  = 5'd10,
    CMD_CLR  = 5'd11,
    CMD_TST  = 5'd12,
    CMD_ASL  = 5'd13,
    CMD_ASR  = 5'd14,
    CMD_LSR  = 5'd15,
    CMD_ROL  = 5'd16,
    CMD_ROR  = 5'd17,
    CMD_DAA  = 5'd18,
    CMD_CPX  = 5'd19,
    CMD_LD16 = 5'd20,
    CMD_LD8  = 5'd21,
    CMD_TAP  = 5'd22,
    CMD_TPA  = 5'd23,
    CMD_CLV  = 5'd24,
    CMD_SEV  = 5'd25,
    CMD_CLC  = 5'd26,
    CMD_SEC  = 5'd27,
    CMD_CLI  = 5'd28,
    CMD_SEI  = 5'd29,
    CMD_INX  = 5'd30,
    CMD_DEX  = 5'd31
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0]  result;
    logic [WIDE_W-1:0]  wide_result;
    logic [FLAGS_W-1:0] flags;
  } alu_out_t;

endpackage

// File: rtl/accalu_core.sv
module accalu_core (
  input  accalu_pkg::cmd_t                  cmd,
  input  logic [accalu_pkg::DATA_W-1:0]     operand_a,
  input  logic [accalu_pkg::DATA_W-1:0]     operand_m,
  input  logic [accalu_pkg::WIDE_W-1:0]     index_value,
  input  logic [accalu_pkg::WIDE_W-1:0]     wide_operand,
  input  logic [accalu_pkg::FLAGS_W-1:0]    flags,
  output accalu_pkg::alu_out_t              alu_out
);

  always_comb begin
    logic [accalu_pkg::DATA_W-1:0]  a;
    logic [accalu_pkg::DATA_W-1:0]  m;
    logic [accalu_pkg::DATA_W-1:0]  res;
    logic [accalu_pkg::WIDE_W-1:0]  wres;
    logic [accalu_pkg::FLAGS_W-1:0] f;
    logic                           cin;
    logic                           ci;
    logic [accalu_pkg::DATA_W:0]    sum9;
    logic [4:0]                     half;
    logic [accalu_pkg::DATA_W:0]    dif9;
    logic                           cout;
    logic [3:0]                     hi;
    logic [3:0]                     lo;
    logic [accalu_pkg::DATA_W-1:0]  adj;
    a    = operand_a;
    m    = operand_m;
    f    = flags;
    cin  = flags[accalu_pkg::FL_C];
    res  = '0;
    wres = '0;
    ci   = (cmd == accalu_pkg::CMD_ADC || cmd == accalu_pkg::CMD_SBC) ? cin : 1'b0;
    sum9 = {1'b0, a} + {1'b0, m} + {{accalu_pkg::DATA_W{1'b0}}, ci};
    half = {1'b0, a[3:0]} + {1'b0, m[3:0]} + {4'b0, ci};
    dif9 = {1'b0, a} - {1'b0, m} - {{accalu_pkg::DATA_W{1'b0}}, ci};
    cout = 1'b0;
    hi   = a[7:4];
    lo   = a[3:0];
    adj  = '0;

    case (cmd)
      accalu_pkg::CMD_ADD, accalu_pkg::CMD_ADC: begin
        res = sum9[accalu_pkg::DATA_W-1:0];
        f[accalu_pkg::FL_H] = half[4];
        f[accalu_pkg::FL_C] = sum9[accalu_pkg::DATA_W];
        f[accalu_pkg::FL_V] = (a[7] ^ res[7]) & (m[7] ^ res[7]);
      end
      accalu_pkg::CMD_SUB, accalu_pkg::CMD_SBC: begin
        res = dif9[accalu_pkg::DATA_W-1:0];
        f[accalu_pkg::FL_C] = dif9[accalu_pkg::DATA_W];
        f[accalu_pkg::FL_V] = (a[7] ^ m[7]) & (a[7] ^ res[7]);
      end
      accalu_pkg::CMD_AND: begin
        res = a & m;
        f[accalu_pkg::FL_V] = 1'b0;
      end
      accalu_pkg::CMD_OR: begin
        res = a | m;
        f[accalu_pkg::FL_V] = 1'b0;
      end
      accalu_pkg::CMD_EOR: begin
        res = a ^ m;
        f[accalu_pkg::FL_V] = 1'b0;
      end
      accalu_pkg::CMD_NEG: begin
        res = '0 - m;
        f[accalu_pkg::FL_V] = (m == accalu_pkg::BYTE_MSB);
        f[accalu_pkg::FL_C] = (m != '0);
      end
      accalu_pkg::CMD_COM: begin
        res = ~m;
        f[accalu_pkg::FL_V] = 1'b0;
        f[accalu_pkg::FL_C] = 1'b1;
      end
      accalu_pkg::CMD_INC: begin
        res = m + 8'd1;
        f[accalu_pkg::FL_V] = (m == accalu_pkg::BYTE_MAXPOS);
      end
      accalu_pkg::CMD_DEC: begin
        res = m - 8'd1;
        f[accalu_pkg::FL_V] = (m == accalu_pkg::BYTE_MSB);
      end
      accalu_pkg::CMD_CLR: begin
        res = '0;
        f[accalu_pkg::FL_V] = 1'b0;
        f[accalu_pkg::FL_C] = 1'b0;
      end
      accalu_pkg::CMD_TST: begin
        f[accalu_pkg::FL_V] = 1'b0;
        f[accalu_pkg::FL_C] = 1'b0;
      end
      accalu_pkg::CMD_ASL: begin
        res  = {m[6:0], 1'b0};
        cout = m[7];
      end
      accalu_pkg::CMD_ASR: begin
        res  = {m[7], m[7:1]};
        cout = m[0];
      end
      accalu_pkg::CMD_LSR: begin
        res  = {1'b0, m[7:1]};
        cout = m[0];
      end
      accalu_pkg::CMD_ROL: begin
        res  = {m[6:0], cin};
        cout = m[7];
      end
      accalu_pkg::CMD_ROR: begin
        res  = {cin, m[7:1]};
        cout = m[0];
      end
      accalu_pkg::CMD_DAA: begin
        if (flags[accalu_pkg::FL_H] || lo > accalu_pkg::BCD_MAX) begin
          adj = adj | accalu_pkg::ADJ_LO;
        end
        if (cin || hi > accalu_pkg::BCD_MAX ||
            (hi == accalu_pkg::BCD_MAX && lo > accalu_pkg::BCD_MAX)) begin
          adj = adj | accalu_pkg::ADJ_HI;
        end
        res = a + adj;
        f[accalu_pkg::FL_C] = (adj & accalu_pkg::ADJ_HI) != '0;
        f[accalu_pkg::FL_V] = 1'b0;
      end
      accalu_pkg::CMD_CPX: begin
        wres = index_value - wide_operand;
        f[accalu_pkg::FL_N] = wres[accalu_pkg::WIDE_W-1];
        f[accalu_pkg::FL_Z] = (wres == '0);
        f[accalu_pkg::FL_V] = (index_value[accalu_pkg::WIDE_W-1] ^
                               wide_operand[accalu_pkg::WIDE_W-1]) &
                              (index_value[accalu_pkg::WIDE_W-1] ^
                               wres[accalu_pkg::WIDE_W-1]);
      end
      accalu_pkg::CMD_LD16: begin
        f[accalu_pkg::FL_N] = wide_operand[accalu_pkg::WIDE_W-1];
        f[accalu_pkg::FL_Z] = (wide_operand == '0);
        f[accalu_pkg::FL_V] = 1'b0;
      end
      accalu_pkg::CMD_LD8: begin
        res = m;
        f[accalu_pkg::FL_V] = 1'b0;
      end
      accalu_pkg::CMD_TAP: f = a[accalu_pkg::FLAGS_W-1:0];
      accalu_pkg::CMD_TPA: res = {accalu_pkg::CCR_TOP, flags};
      accalu_pkg::CMD_CLV: f[accalu_pkg::FL_V] = 1'b0;
      accalu_pkg::CMD_SEV: f[accalu_pkg::FL_V] = 1'b1;
      accalu_pkg::CMD_CLC: f[accalu_pkg::FL_C] = 1'b0;
      accalu_pkg::CMD_SEC: f[accalu_pkg::FL_C] = 1'b1;
      accalu_pkg::CMD_CLI: f[accalu_pkg::FL_I] = 1'b0;
      accalu_pkg::CMD_SEI: f[accalu_pkg::FL_I] = 1'b1;
      accalu_pkg::CMD_INX: begin
        wres = index_value + 16'd1;
        f[accalu_pkg::FL_Z] = (wres == '0);
      end
      default: begin
        wres = index_value - 16'd1;
        f[accalu_pkg::FL_Z] = (wres == '0);
      end
    endcase

    // 8-bit n and z
    case (cmd)
      accalu_pkg::CMD_ADD, accalu_pkg::CMD_ADC, accalu_pkg::CMD_SUB,
      accalu_pkg::CMD_SBC, accalu_pkg::CMD_AND, accalu_pkg::CMD_OR,
      accalu_pkg::CMD_EOR, accalu_pkg::CMD_NEG, accalu_pkg::CMD_COM,
      accalu_pkg::CMD_INC, accalu_pkg::CMD_DEC, accalu_pkg::CMD_CLR,
      accalu_pkg::CMD_ASL, accalu_pkg::CMD_ASR, accalu_pkg::CMD_LSR,
      accalu_pkg::CMD_ROL, accalu_pkg::CMD_ROR, accalu_pkg::CMD_DAA,
      accalu_pkg::CMD_LD8: begin
        f[accalu_pkg::FL_N] = res[accalu_pkg::DATA_W-1];
        f[accalu_pkg::FL_Z] = (res == '0);
      end
      accalu_pkg::CMD_TST: begin
        f[accalu_pkg::FL_N] = m[accalu_pkg::DATA_W-1];
        f[accalu_pkg::FL_Z] = (m == '0);
      end
      default: ;
    endcase

    // shifts and rotates
    case (cmd)
      accalu_pkg::CMD_ASL, accalu_pkg::CMD_ASR, accalu_pkg::CMD_LSR,
      accalu_pkg::CMD_ROL, accalu_pkg::CMD_ROR: begin
        f[accalu_pkg::FL_C] = cout;
        f[accalu_pkg::FL_V] = res[accalu_pkg::DATA_W-1] ^ cout;
      end
      default: ;
    endcase

    alu_out.result      = res;
    alu_out.wide_result = wres;
    alu_out.flags       = f;
  end

endmodule

// File: rtl/accumulator_alu_with_condition_codes_top.sv
// channel | beat fields                                          | handshake
// in      | cmd operand_a operand_m index_value wide_operand     | in_valid / in_ready
// out     | result wide_result ccr                               | out_valid / out_ready
//
// one beat per cycle sustained while out_ready is high; an accepted beat reaches the output
// through the input register, the single-pass alu and the result register
// flags update as a beat moves into the result register, so the next beat sees them
// reset is synchronous; flags come up with only i set, both stages empty
// a stalled output holds its beat, and the input stage keeps one beat behind it
module accumulator_alu_with_condition_codes_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [accalu_pkg::CMD_W-1:0]       cmd,
  input  logic [accalu_pkg::DATA_W-1:0]      operand_a,
  input  logic [accalu_pkg::DATA_W-1:0]      operand_m,
  input  logic [accalu_pkg::WIDE_W-1:0]      index_value,
  input  logic [accalu_pkg::WIDE_W-1:0]      wide_operand,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [accalu_pkg::DATA_W-1:0]      result,
  output logic [accalu_pkg::WIDE_W-1:0]      wide_result,
  output logic [accalu_pkg::DATA_W-1:0]      ccr
);

  logic                            s1_valid;
  accalu_pkg::cmd_t                s1_cmd;
  logic [accalu_pkg::DATA_W-1:0]   s1_a;
  logic [accalu_pkg::DATA_W-1:0]   s1_m;
  logic [accalu_pkg::WIDE_W-1:0]   s1_x;
  logic [accalu_pkg::WIDE_W-1:0]   s1_w;
  logic [accalu_pkg::FLAGS_W-1:0]  flags;
  logic [accalu_pkg::FLAGS_W-1:0]  out_flags;
  accalu_pkg::alu_out_t            alu_out;
  logic                            advance;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  accalu_core u_core (
    .cmd          (s1_cmd),
    .operand_a    (s1_a),
    .operand_m    (s1_m),
    .index_value  (s1_x),
    .wide_operand (s1_w),
    .flags        (flags),
    .alu_out      (alu_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_cmd <= accalu_pkg::cmd_t'(cmd);
      s1_a   <= operand_a;
      s1_m   <= operand_m;
      s1_x   <= index_value;
      s1_w   <= wide_operand;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      flags     <= accalu_pkg::FLAGS_RESET;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        flags     <= alu_out.flags;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      result      <= alu_out.result;
      wide_result <= alu_out.wide_result;
      out_flags   <= alu_out.flags;
    end
  end

  assign ccr = {accalu_pkg::CCR_TOP, out_flags};

endmodule

// File: dv/accumulator_alu_with_condition_codes_top_tb.sv
module accumulator_alu_with_condition_codes_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import accalu_pkg::*;

  localparam int RAND_BEATS  = 750;
  localparam int QUIET_BEATS = 100;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    cmd_t              cmd;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] m;
    logic [WIDE_W-1:0] x;
    logic [WIDE_W-1:0] w;
  } alu_beat_t;

  typedef struct packed {
    logic [DATA_W-1:0] res;
    logic [WIDE_W-1:0] wide;
    logic [DATA_W-1:0] ccr;
  } alu_res_t;

  typedef struct packed {
    alu_beat_t beat;
    logic      typed;
    alu_res_t  fixed;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CMD_W-1:0]  cmd = '0;
  logic [DATA_W-1:0] operand_a = '0;
  logic [DATA_W-1:0] operand_m = '0;
  logic [WIDE_W-1:0] index_value = '0;
  logic [WIDE_W-1:0] wide_operand = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [DATA_W-1:0] result;
  logic [WIDE_W-1:0] wide_result;
  logic [DATA_W-1:0] ccr;

  logic [FLAGS_W-1:0] cc_state = FLAGS_RESET;
  alu_res_t           expected_outs[$];
  dir_row_t           dir_rows[$];
  int                 n_err = 0;
  int                 cycles = 0;
  bit                 quiet = 1'b0;

  accumulator_alu_with_condition_codes_top uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .operand_a(operand_a),
    .operand_m(operand_m),
    .index_value(index_value),
    .wide_operand(wide_operand),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result(result),
    .wide_result(wide_result),
    .ccr(ccr)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d beats outstanding", $time, expected_outs.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // updates the flag state and returns the beat the alu should produce
  function automatic alu_res_t exec_alu_op(alu_beat_t b);
    logic [DATA_W:0]   sum9;
    logic [4:0]        nib;
    logic [DATA_W-1:0] r;
    logic [WIDE_W-1:0] wr;
    logic [DATA_W-1:0] adj;
    logic              cin;
    logic              sc;
    logic              upd_nz;
    logic              shift_v;
    alu_res_t          o;
    r = '0;
    wr = '0;
    adj = '0;
    cin = cc_state[FL_C];
    sc = 1'b0;
    upd_nz = 1'b1;
    shift_v = 1'b0;
    case (b.cmd)
      CMD_ADD, CMD_ADC: begin
        sc = (b.cmd == CMD_ADC) ? cin : 1'b0;
        sum9 = {1'b0, b.a} + {1'b0, b.m} + {8'd0, sc};
        nib = {1'b0, b.a[3:0]} + {1'b0, b.m[3:0]} + {4'd0, sc};
        r = sum9[DATA_W-1:0];
        cc_state[FL_H] = nib[4];
        cc_state[FL_C] = sum9[DATA_W];
        cc_state[FL_V] = (b.a[7] ^ r[7]) & (b.m[7] ^ r[7]);
      end
      CMD_SUB, CMD_SBC: begin
        sc = (b.cmd == CMD_SBC) ? cin : 1'b0;
        sum9 = {1'b0, b.a} - {1'b0, b.m} - {8'd0, sc};
        r = sum9[DATA_W-1:0];
        cc_state[FL_C] = sum9[DATA_W];
        cc_state[FL_V] = (b.a[7] ^ b.m[7]) & (b.a[7] ^ r[7]);
      end
      CMD_AND: begin
        r = b.a & b.m;
        cc_state[FL_V] = 1'b0;
      end
      CMD_OR: begin
        r = b.a | b.m;
        cc_state[FL_V] = 1'b0;
      end
      CMD_EOR: begin
        r = b.a ^ b.m;
        cc_state[FL_V] = 1'b0;
      end
      CMD_NEG: begin
        r = 8'd0 - b.m;
        cc_state[FL_V] = (b.m == BYTE_MSB);
        cc_state[FL_C] = (b.m != 8'd0);
      end
      CMD_COM: begin
        r = ~b.m;
        cc_state[FL_V] = 1'b0;
        cc_state[FL_C] = 1'b1;
      end
      CMD_INC: begin
        r = b.m + 8'd1;
        cc_state[FL_V] = (b.m == BYTE_MAXPOS);
      end
      CMD_DEC: begin
        r = b.m - 8'd1;
        cc_state[FL_V] = (b.m == BYTE_MSB);
      end
      CMD_CLR: begin
        cc_state[FL_V] = 1'b0;
        cc_state[FL_C] = 1'b0;
      end
      CMD_TST: begin
        upd_nz = 1'b0;
        cc_state[FL_N] = b.m[7];
        cc_state[FL_Z] = (b.m == 8'd0);
        cc_state[FL_V] = 1'b0;
        cc_state[FL_C] = 1'b0;
      end
      CMD_ASL: begin
        r = {b.m[6:0], 1'b0};
        cc_state[FL_C] = b.m[7];
        shift_v = 1'b1;
      end
      CMD_ASR: begin
        r = {b.m[7], b.m[7:1]};
        cc_state[FL_C] = b.m[0];
        shift_v = 1'b1;
      end
      CMD_LSR: begin
        r = {1'b0, b.m[7:1]};
        cc_state[FL_C] = b.m[0];
        shift_v = 1'b1;
      end
      CMD_ROL: begin
        r = {b.m[6:0], cin};
        cc_state[FL_C] = b.m[7];
        shift_v = 1'b1;
      end
      CMD_ROR: begin
        r = {cin, b.m[7:1]};
        cc_state[FL_C] = b.m[0];
        shift_v = 1'b1;
      end
      CMD_DAA: begin
        if (cc_state[FL_H] || b.a[3:0] > BCD_MAX) adj = adj | ADJ_LO;
        if (cc_state[FL_C] || b.a[7:4] > BCD_MAX ||
            (b.a[7:4] == BCD_MAX && b.a[3:0] > BCD_MAX)) adj = adj | ADJ_HI;
        r = b.a + adj;
        cc_state[FL_C] = |(adj & ADJ_HI);
        cc_state[FL_V] = 1'b0;
      end
      CMD_CPX: begin
        upd_nz = 1'b0;
        wr = b.x - b.w;
        cc_state[FL_N] = wr[WIDE_W-1];
        cc_state[FL_Z] = (wr == '0);
        cc_state[FL_V] = (b.x[WIDE_W-1] ^ b.w[WIDE_W-1]) & (b.x[WIDE_W-1] ^ wr[WIDE_W-1]);
      end
      CMD_LD16: begin
        upd_nz = 1'b0;
        cc_state[FL_N] = b.w[WIDE_W-1];
        cc_state[FL_Z] = (b.w == '0);
        cc_state[FL_V] = 1'b0;
      end
      CMD_LD8: begin
        r = b.m;
        cc_state[FL_V] = 1'b0;
      end
      CMD_TAP: begin
        upd_nz = 1'b0;
        cc_state = b.a[FLAGS_W-1:0];
      end
      CMD_TPA: begin
        upd_nz = 1'b0;
        r = {CCR_TOP, cc_state};
      end
      CMD_CLV: begin
        upd_nz = 1'b0;
        cc_state[FL_V] = 1'b0;
      end
      CMD_SEV: begin
        upd_nz = 1'b0;
        cc_state[FL_V] = 1'b1;
      end
      CMD_CLC: begin
        upd_nz = 1'b0;
        cc_state[FL_C] = 1'b0;
      end
      CMD_SEC: begin
        upd_nz = 1'b0;
        cc_state[FL_C] = 1'b1;
      end
      CMD_CLI: begin
        upd_nz = 1'b0;
        cc_state[FL_I] = 1'b0;
      end
      CMD_SEI: begin
        upd_nz = 1'b0;
        cc_state[FL_I] = 1'b1;
      end
      CMD_INX: begin
        upd_nz = 1'b0;
        wr = b.x + 16'd1;
        cc_state[FL_Z] = (wr == '0);
      end
      default: begin
        upd_nz = 1'b0;
        wr = b.x - 16'd1;
        cc_state[FL_Z] = (wr == '0);
      end
    endcase
    if (upd_nz) begin
      cc_state[FL_N] = r[7];
      cc_state[FL_Z] = (r == '0);
    end
    if (shift_v) cc_state[FL_V] = cc_state[FL_N] ^ cc_state[FL_C];
    o.res = r;
    o.wide = wr;
    o.ccr = {CCR_TOP, cc_state};
    return o;
  endfunction

  function automatic logic [DATA_W-1:0] pick_byte();
    logic [DATA_W-1:0] corners[5];
    corners = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF};
    if ($urandom_range(0, 3) == 0) return corners[$urandom_range(0, 4)];
    return DATA_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [WIDE_W-1:0] pick_word();
    logic [WIDE_W-1:0] corners[5];
    corners = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFF};
    if ($urandom_range(0, 3) == 0) return corners[$urandom_range(0, 4)];
    return WIDE_W'($urandom_range(0, 65535));
  endfunction

  function automatic void add_dir_row(cmd_t c, logic [DATA_W-1:0] a, logic [DATA_W-1:0] m,
                                      logic [WIDE_W-1:0] x, logic [WIDE_W-1:0] w,
                                      logic typed, logic [DATA_W-1:0] e_res,
                                      logic [WIDE_W-1:0] e_wide, logic [DATA_W-1:0] e_ccr);
    dir_row_t row;
    row.beat.cmd = c;
    row.beat.a = a;
    row.beat.m = m;
    row.beat.x = x;
    row.beat.w = w;
    row.typed = typed;
    row.fixed.res = e_res;
    row.fixed.wide = e_wide;
    row.fixed.ccr = e_ccr;
    dir_rows.push_back(row);
  endfunction

  // called just after a rising edge; returns just after the edge that accepts the beat
  task automatic send_beat(alu_beat_t b, logic typed, alu_res_t fixed);
    alu_res_t pred;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      cmd <= CMD_W'($urandom_range(0, 31));
      operand_a <= DATA_W'($urandom_range(0, 255));
      operand_m <= DATA_W'($urandom_range(0, 255));
      index_value <= WIDE_W'($urandom_range(0, 65535));
      wide_operand <= WIDE_W'($urandom_range(0, 65535));
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= b.cmd;
    operand_a <= b.a;
    operand_m <= b.m;
    index_value <= b.x;
    wide_operand <= b.w;
    do @(posedge clk); while (!in_ready);
    pred = exec_alu_op(b);
    expected_outs.push_back(typed ? fixed : pred);
  endtask

  always @(posedge clk) begin
    alu_res_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_outs.size() == 0) begin
        $display("%0t: unexpected beat result=%02h wide_result=%04h ccr=%02h",
                 $time, result, wide_result, ccr);
        n_err++;
      end else begin
        want = expected_outs.pop_front();
        if (result !== want.res) begin
          $display("%0t: result expected %02h got %02h", $time, want.res, result);
          n_err++;
        end
        if (wide_result !== want.wide) begin
          $display("%0t: wide_result expected %04h got %04h", $time, want.wide, wide_result);
          n_err++;
        end
        if (ccr !== want.ccr) begin
          $display("%0t: ccr expected %02h got %02h", $time, want.ccr, ccr);
          n_err++;
        end
      end
    end
  end

  initial begin
    while (rst) @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      if (!quiet && $urandom_range(0, 1) == 1) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
  end

  initial begin
    alu_beat_t b;
    alu_res_t  none;
    none = '0;

    add_dir_row(CMD_TPA,  8'h00, 8'h00, 16'h0000, 16'h0000, 1'b1, 8'hD0, 16'h0000, 8'hD0);
    add_dir_row(CMD_ADD,  8'hFF, 8'h01, 16'h0000, 16'h0000, 1'b1, 8'h00, 16'h0000, 8'hF5);
    add_dir_row(CMD_ADC,  8'h7F, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00);
    add_dir_row(CMD_SUB,  8'h00, 8'h01, 16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00);
    add_dir_row(CMD_SBC,  8'h80, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00);
    add_dir_row(CMD_AND,  8'hF0, 8'h0F, 16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00);
    add_dir_row(CMD_OR,   8'h80, 8'h01, 16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00);
    add_dir_row(CMD_EOR,  8'hFF, 8'hFF, 16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00);
    add_dir_row(CMD_NEG,  8'h00, 8'h80, 16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00);
    add_dir_row(CMD_NEG,  8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00);
    add_dir_row(CMD_COM,  8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00);
    add_dir_row(CMD_INC,  8'h00, 8'h7F, 16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00);
    add_dir_row(CMD_DEC,  8'h00, 8'h80, 16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00);
    add_dir_row(CMD_CLR,  8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, 8'h00, 16'h0000, 8'h00);
    add_dir_row(CMD_TST,  8'h00, 8'h80, 16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00);
    add_dir_row(CMD_ASL,  8'h00, 8'h81, 16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00);
    add_dir_row(CMD_ASR,  8'h00, 8'h81, 16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00);
    add_dir_row(CMD_LSR,  8'h00, 8'h01, 16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00);
    add_dir_row(CMD_ROL,  8'h00, 8'h80, 16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00);
    add_dir_row(CMD_ROR,  8'h00, 8'h01, 16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00);
    add_dir_row(CMD_TAP,  8'hFF, 8'h00, 16'h0000, 16'h0000, 1'b1, 8'h00, 16'h0000, 8'hFF);
    add_dir_row(CMD_DAA,  8'h9A, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00);
    add_dir_row(CMD_CPX,  8'h00, 8'h00, 16'h8000, 16'h0001, 1'b0, 8'h00, 16'h0000, 8'h00);
    add_dir_row(CMD_LD16, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00);
    add_dir_row(CMD_LD8,  8'h00, 8'hFF, 16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00);
    add_dir_row(CMD_TAP,  8'h00, 8'h00, 16'h0000, 16'h0000, 1'b1, 8'h00, 16'h0000, 8'hC0);
    add_dir_row(CMD_SEV,  8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00);
    add_dir_row(CMD_SEC,  8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00);
    add_dir_row(CMD_SEI,  8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00);
    add_dir_row(CMD_CLV,  8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00);
    add_dir_row(CMD_CLC,  8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00);
    add_dir_row(CMD_CLI,  8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00);
    add_dir_row(CMD_INX,  8'h00, 8'h00, 16'hFFFF, 16'h0000, 1'b1, 8'h00, 16'h0000, 8'hC4);
    add_dir_row(CMD_DEX,  8'h00, 8'h00, 16'h0000, 16'h0000, 1'b1, 8'h00, 16'hFFFF, 8'hC0);
    add_dir_row(CMD_DAA,  8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00);
    add_dir_row(CMD_CPX,  8'h00, 8'h00, 16'h0000, 16'hFFFF, 1'b0, 8'h00, 16'h0000, 8'h00);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].fixed);

    for (int i = 0; i < RAND_BEATS; ) begin
      quiet = (RAND_BEATS - i) <= QUIET_BEATS;
      b.x = pick_word();
      b.w = pick_word();
      if ($urandom_range(0, 7) == 0) begin
        // packed bcd add followed by its decimal adjust
        b.cmd = CMD_ADD;
        b.a = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
        b.m = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
        send_beat(b, 1'b0, none);
        b.cmd = CMD_DAA;
        b.a = b.a + b.m;
        b.m = pick_byte();
        send_beat(b, 1'b0, none);
        i += 2;
      end else begin
        b.cmd = cmd_t'($urandom_range(0, 31));
        b.a = pick_byte();
        b.m = pick_byte();
        send_beat(b, 1'b0, none);
        i++;
      end
    end
    in_valid <= 1'b0;

    while (expected_outs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (n_err == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: accumulator_alu_with_condition_codes_top.f
rtl/accalu_pkg.sv
rtl/accalu_core.sv
rtl/accumulator_alu_with_condition_codes_top.sv
dv/accumulator_alu_with_condition_codes_top_tb.sv
